// ===== src/cfp_pkg.sv =====
// Shared types, constants and the CRC-16 step function of the frame parser.
// Depends on nothing; every other file of the parser imports it.
`default_nettype none

package cfp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int DATA_W      = 8;
    localparam int CNT_W       = 16;
    localparam int CRC_W       = 16;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int BIDX_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int DISC_W      = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_GOOD    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 2'd3;

    localparam logic [DATA_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [DATA_W-1:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [DATA_W-1:0] FRAME_TYPE_RST  = 8'h01;
    localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST = LEN_W'(20);

    typedef enum logic [1:0] {
        CRC_HOLD,
        CRC_LOAD,
        CRC_FEED
    } crc_op_t;

    typedef struct packed {
        logic                  load;
        logic [STATUS_W-1:0]   status;
        logic [IDX_W-1:0]      rd_idx;
        logic                  last;
        logic [DISC_W-1:0]     disc_add;
        logic                  good_inc;
        logic                  err_inc;
        crc_op_t               crc_op;
        logic                  store_wr;
        logic [IDX_W-1:0]      store_idx;
        logic                  crc_lo_wr;
    } cmd_t;

    typedef struct packed {
        logic              sync1_hit;
        logic              sync2_hit;
        logic              type_hit;
        logic              len_hit;
        logic              crc_hit;
        logic              out_free;
        logic [LEN_W-1:0]  eff_len;
    } stat_t;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < DATA_W; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/cfp_byte_if.sv =====
// Request channel that carries one received byte.
// Depends on cfp_pkg for the byte width.
`default_nettype none

interface cfp_byte_if;
    import cfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/cfp_result_if.sv =====
// Request channel that carries one parser result.
// Depends on cfp_pkg for the field widths.
`default_nettype none

interface cfp_result_if;
    import cfp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   payload_byte;
    logic [IDX_W-1:0]    payload_index;
    logic                last;
    logic [CNT_W-1:0]    discarded_count;
    logic [CNT_W-1:0]    good_count;
    logic [CNT_W-1:0]    crc_error_count;

    modport source (output valid, output status, output payload_byte, output payload_index,
                    output last, output discarded_count, output good_count,
                    output crc_error_count, input ready);
    modport sink   (input valid, input status, input payload_byte, input payload_index,
                    input last, input discarded_count, input good_count,
                    input crc_error_count, output ready);
endinterface

`default_nettype wire

// ===== src/cfp_datapath.sv =====
// Datapath of the frame parser: configuration, matchers, CRC, payload store,
// counters and the result register. Depends on cfp_pkg.
`default_nettype none

module cfp_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cfp_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic [cfp_pkg::DATA_W-1:0]    rx_byte,
    input  wire cfp_pkg::cmd_t                 cmd,
    output cfp_pkg::stat_t                     stat,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [cfp_pkg::STATUS_W-1:0]       status,
    output logic [cfp_pkg::DATA_W-1:0]         payload_byte,
    output logic [cfp_pkg::IDX_W-1:0]          payload_index,
    output logic                               last,
    output logic [cfp_pkg::CNT_W-1:0]          discarded_count,
    output logic [cfp_pkg::CNT_W-1:0]          good_count,
    output logic [cfp_pkg::CNT_W-1:0]          crc_error_count
);
    import cfp_pkg::*;

    logic [DATA_W-1:0]   sync_first_reg;
    logic [DATA_W-1:0]   sync_second_reg;
    logic [DATA_W-1:0]   frame_type_reg;
    logic [LEN_W-1:0]    payload_len_reg;
    logic [LEN_W-1:0]    eff_len;

    logic [CRC_W-1:0]    crc_reg;
    logic [CRC_W-1:0]    crc_next;
    logic [DATA_W-1:0]   crc_lo_reg;

    logic [CNT_W-1:0]    disc_reg;
    logic [CNT_W-1:0]    disc_next;
    logic [CNT_W-1:0]    good_reg;
    logic [CNT_W-1:0]    good_next;
    logic [CNT_W-1:0]    err_reg;
    logic [CNT_W-1:0]    err_next;

    logic [DATA_W-1:0]   store_mem [MAX_PAYLOAD];

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   byte_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    disc_out_reg;
    logic [CNT_W-1:0]    good_out_reg;
    logic [CNT_W-1:0]    err_out_reg;

    always_comb
    begin
        if (payload_len_reg == '0)
            eff_len = LEN_W'(1);
        else if (payload_len_reg > LEN_W'(MAX_PAYLOAD))
            eff_len = LEN_W'(MAX_PAYLOAD);
        else
            eff_len = payload_len_reg;
    end

    always_comb
    begin
        case (cmd.crc_op)
            CRC_LOAD: crc_next = crc_feed(CRC_SEED, rx_byte);
            CRC_FEED: crc_next = crc_feed(crc_reg, rx_byte);
            default:  crc_next = crc_reg;
        endcase
    end

    assign disc_next = disc_reg + CNT_W'(cmd.disc_add);
    assign good_next = good_reg + CNT_W'(cmd.good_inc);
    assign err_next  = err_reg + CNT_W'(cmd.err_inc);

    assign stat.sync1_hit = (rx_byte == sync_first_reg);
    assign stat.sync2_hit = (rx_byte == sync_second_reg);
    assign stat.type_hit  = (rx_byte == frame_type_reg);
    assign stat.len_hit   = (rx_byte == DATA_W'(eff_len));
    assign stat.crc_hit   = ({rx_byte, crc_lo_reg} == crc_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.eff_len   = eff_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            frame_type_reg  <= FRAME_TYPE_RST;
            payload_len_reg <= PAYLOAD_LEN_RST;
            crc_reg         <= CRC_SEED;
            crc_lo_reg      <= '0;
            disc_reg        <= '0;
            good_reg        <= '0;
            err_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                    CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                    CFG_FRAME_TYPE:  frame_type_reg  <= cfg_data;
                    CFG_PAYLOAD_LEN: payload_len_reg <= cfg_data[LEN_W-1:0];
                    default:         ;
                endcase
            end
            crc_reg <= crc_next;
            if (cmd.crc_lo_wr)
                crc_lo_reg <= rx_byte;
            disc_reg <= disc_next;
            good_reg <= good_next;
            err_reg  <= err_next;
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
            store_mem[cmd.store_idx] <= rx_byte;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg   <= cmd.status;
            last_reg     <= cmd.last;
            disc_out_reg <= disc_next;
            good_out_reg <= good_next;
            err_out_reg  <= err_next;
            if (cmd.status == STATUS_GOOD)
            begin
                byte_reg <= store_mem[cmd.rd_idx];
                idx_reg  <= cmd.rd_idx;
            end
            else
            begin
                byte_reg <= '0;
                idx_reg  <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign payload_byte    = byte_reg;
    assign payload_index   = idx_reg;
    assign last            = last_reg;
    assign discarded_count = disc_out_reg;
    assign good_count      = good_out_reg;
    assign crc_error_count = err_out_reg;

endmodule

`default_nettype wire

// ===== src/cfp_controller.sv =====
// Frame state machine of the parser: walks the header, payload and CRC bytes
// and sequences the payload burst. Depends on cfp_pkg.
`default_nettype none

module cfp_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cfp_pkg::stat_t stat,
    output cfp_pkg::cmd_t       cmd
);
    import cfp_pkg::*;

    typedef enum logic [7:0] {
        ST_SYNC1  = 8'b0000_0001,
        ST_SYNC2  = 8'b0000_0010,
        ST_TYPE   = 8'b0000_0100,
        ST_LEN    = 8'b0000_1000,
        ST_PAY    = 8'b0001_0000,
        ST_CRCLO  = 8'b0010_0000,
        ST_CRCHI  = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [BIDX_W-1:0] bidx_reg;
    logic [BIDX_W-1:0] bidx_next;
    logic [BIDX_W-1:0] bidx_inc;
    logic              in_fire;

    assign in_ready = (state_reg != ST_EMIT) && stat.out_free;
    assign in_fire  = in_ready && in_valid;
    assign bidx_inc = bidx_reg + BIDX_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        bidx_next     = bidx_reg;
        cmd           = '0;
        cmd.crc_op    = CRC_HOLD;
        cmd.load      = in_fire;
        cmd.status    = STATUS_NONE;
        cmd.last      = 1'b1;
        cmd.store_idx = bidx_reg[IDX_W-1:0];
        cmd.rd_idx    = bidx_reg[IDX_W-1:0];

        case (state_reg)
            ST_SYNC1:
            begin
                if (in_fire)
                begin
                    if (stat.sync1_hit)
                        state_next = ST_SYNC2;
                    else
                        cmd.disc_add = DISC_W'(1);
                end
            end
            ST_SYNC2:
            begin
                if (in_fire)
                begin
                    if (stat.sync2_hit)
                        state_next = ST_TYPE;
                    else if (stat.sync1_hit)
                        cmd.disc_add = DISC_W'(1);
                    else
                    begin
                        cmd.disc_add = DISC_W'(2);
                        state_next   = ST_SYNC1;
                    end
                end
            end
            ST_TYPE:
            begin
                if (in_fire)
                begin
                    if (stat.type_hit)
                    begin
                        cmd.crc_op = CRC_LOAD;
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        cmd.disc_add = DISC_W'(3);
                        state_next   = ST_SYNC1;
                    end
                end
            end
            ST_LEN:
            begin
                if (in_fire)
                begin
                    if (stat.len_hit)
                    begin
                        cmd.crc_op = CRC_FEED;
                        bidx_next  = '0;
                        state_next = ST_PAY;
                    end
                    else
                    begin
                        cmd.disc_add = DISC_W'(4);
                        state_next   = ST_SYNC1;
                    end
                end
            end
            ST_PAY:
            begin
                if (in_fire)
                begin
                    cmd.store_wr = (bidx_reg < BIDX_W'(MAX_PAYLOAD));
                    cmd.crc_op   = CRC_FEED;
                    bidx_next    = bidx_inc;
                    if (bidx_inc >= BIDX_W'(stat.eff_len))
                        state_next = ST_CRCLO;
                end
            end
            ST_CRCLO:
            begin
                if (in_fire)
                begin
                    cmd.crc_lo_wr = 1'b1;
                    state_next    = ST_CRCHI;
                end
            end
            ST_CRCHI:
            begin
                if (in_fire)
                begin
                    state_next = ST_SYNC1;
                    if (stat.crc_hit)
                    begin
                        cmd.good_inc = 1'b1;
                        cmd.status   = STATUS_GOOD;
                        cmd.rd_idx   = '0;
                        cmd.last     = (stat.eff_len == LEN_W'(1));
                        if (!cmd.last)
                        begin
                            bidx_next  = BIDX_W'(1);
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        cmd.err_inc = 1'b1;
                        cmd.status  = STATUS_CRC_ERR;
                    end
                end
            end
            ST_EMIT:
            begin
                cmd.load   = stat.out_free;
                cmd.status = STATUS_GOOD;
                cmd.last   = (bidx_inc == BIDX_W'(stat.eff_len));
                if (stat.out_free)
                begin
                    bidx_next = bidx_inc;
                    if (cmd.last)
                        state_next = ST_SYNC1;
                end
            end
            default:
            begin
                if (in_fire)
                    state_next = ST_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SYNC1;
            bidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bidx_reg  <= bidx_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/crc16_frame_parser.sv =====
// Top level of the CRC-16 framed packet parser: controller and datapath.
// Depends on cfp_pkg, cfp_byte_if, cfp_result_if, cfp_controller, cfp_datapath.
//
//   channel    direction  contents
//   byte_ch    sink       rx_byte
//   result_ch  source     status, payload_byte, payload_index, last, three counters
//   cfg_*      write      cfg_we, cfg_index, cfg_data
//
// Each received byte yields one result in the output register. A good CRC yields a
// burst of one result per payload byte, one per cycle while results do not stall,
// through the payload store read port; the byte channel is held off for the others.
// A stalled result channel holds the output register and stops byte acceptance.
// Reset is asynchronous and active low; the payload store needs no clearing.
`default_nettype none

module crc16_frame_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cfp_pkg::DATA_W-1:0]    cfg_data,
    cfp_byte_if.sink                           byte_ch,
    cfp_result_if.source                       result_ch
);
    import cfp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cfp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .in_ready (byte_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cfp_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rx_byte         (byte_ch.rx_byte),
        .cmd             (cmd),
        .stat            (stat),
        .out_ready       (result_ch.ready),
        .out_valid       (result_ch.valid),
        .status          (result_ch.status),
        .payload_byte    (result_ch.payload_byte),
        .payload_index   (result_ch.payload_index),
        .last            (result_ch.last),
        .discarded_count (result_ch.discarded_count),
        .good_count      (result_ch.good_count),
        .crc_error_count (result_ch.crc_error_count)
    );

endmodule

`default_nettype wire

// ===== tb/cfp_frame_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the CRC-16 frame parser: a bit-accurate predictor of the parser
// and a field-by-field comparison of every result request. Depends on cfp_pkg and
// the two channel interfaces; the small package below is shared with the stimulus.

package cfp_tb_pkg;
    import cfp_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   payload_byte;
        logic [IDX_W-1:0]    payload_index;
        logic                last;
        logic [CNT_W-1:0]    discarded;
        logic [CNT_W-1:0]    good;
        logic [CNT_W-1:0]    crc_errors;
    } frame_result_t;

    function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                      input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] acc;
        logic             fb;
        acc = crc;
        for (int i = DATA_W - 1; i >= 0; i--)
        begin
            fb  = acc[CRC_W-1] ^ b[i];
            acc = {acc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return acc;
    endfunction

    function automatic logic [LEN_W-1:0] payload_span(input logic [LEN_W-1:0] len_reg);
        if (len_reg == '0)
            return LEN_W'(1);
        if (len_reg > LEN_W'(MAX_PAYLOAD))
            return LEN_W'(MAX_PAYLOAD);
        return len_reg;
    endfunction
endpackage

module cfp_frame_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cfp_pkg::DATA_W-1:0]    cfg_data,
    cfp_byte_if                       byte_ch,
    cfp_result_if                     result_ch,
    output int                        mismatch_count,
    output int                        results_due,
    output logic                      parser_hunting,
    output int                        bytes_taken,
    output int                        results_taken,
    output int                        frames_passed,
    output int                        frames_corrupt
);
    import cfp_pkg::*;
    import cfp_tb_pkg::*;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        WANT_TYPE,
        WANT_LEN,
        IN_PAYLOAD,
        WANT_CRC_LO,
        WANT_CRC_HI
    } parse_state_t;

    logic [DATA_W-1:0] sync_first_q;
    logic [DATA_W-1:0] sync_second_q;
    logic [DATA_W-1:0] frame_type_q;
    logic [LEN_W-1:0]  length_q;

    parse_state_t      state;
    logic [BIDX_W-1:0] fill_idx;
    logic [DATA_W-1:0] payload_copy [MAX_PAYLOAD];
    logic [CRC_W-1:0]  crc_acc;
    logic [DATA_W-1:0] crc_lo;
    logic [CNT_W-1:0]  discards;
    logic [CNT_W-1:0]  goods;
    logic [CNT_W-1:0]  crc_errs;

    frame_result_t     results_q [$];

    task automatic parse_byte(input logic [DATA_W-1:0] b);
        logic [LEN_W-1:0]    span;
        logic [STATUS_W-1:0] st;
        frame_result_t       r;
        span = payload_span(length_q);
        st   = STATUS_NONE;
        case (state)
            HUNT_FIRST:
                if (b == sync_first_q)
                    state = HUNT_SECOND;
                else
                    discards = discards + 16'd1;
            HUNT_SECOND:
                if (b == sync_second_q)
                    state = WANT_TYPE;
                else if (b == sync_first_q)
                    discards = discards + 16'd1;
                else
                begin
                    discards = discards + 16'd2;
                    state    = HUNT_FIRST;
                end
            WANT_TYPE:
                if (b == frame_type_q)
                begin
                    crc_acc = crc16_update(CRC_SEED, b);
                    state   = WANT_LEN;
                end
                else
                begin
                    discards = discards + 16'd3;
                    state    = HUNT_FIRST;
                end
            WANT_LEN:
                if (b == DATA_W'(span))
                begin
                    crc_acc  = crc16_update(crc_acc, b);
                    fill_idx = '0;
                    state    = IN_PAYLOAD;
                end
                else
                begin
                    discards = discards + 16'd4;
                    state    = HUNT_FIRST;
                end
            IN_PAYLOAD:
            begin
                payload_copy[fill_idx[IDX_W-1:0]] = b;
                crc_acc  = crc16_update(crc_acc, b);
                fill_idx = fill_idx + BIDX_W'(1);
                if (fill_idx >= BIDX_W'(span))
                    state = WANT_CRC_LO;
            end
            WANT_CRC_LO:
            begin
                crc_lo = b;
                state  = WANT_CRC_HI;
            end
            default:
            begin
                state = HUNT_FIRST;
                if ({b, crc_lo} == crc_acc)
                begin
                    goods = goods + 16'd1;
                    st    = STATUS_GOOD;
                    frames_passed++;
                end
                else
                begin
                    crc_errs = crc_errs + 16'd1;
                    st       = STATUS_CRC_ERR;
                    frames_corrupt++;
                end
            end
        endcase

        r.status     = st;
        r.discarded  = discards;
        r.good       = goods;
        r.crc_errors = crc_errs;
        if (st == STATUS_GOOD)
        begin
            for (int k = 0; k < int'(span); k++)
            begin
                r.payload_byte  = payload_copy[k];
                r.payload_index = IDX_W'(k);
                r.last          = (k == int'(span) - 1);
                results_q.push_back(r);
            end
        end
        else
        begin
            r.payload_byte  = '0;
            r.payload_index = '0;
            r.last          = 1'b1;
            results_q.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            sync_first_q   = SYNC_FIRST_RST;
            sync_second_q  = SYNC_SECOND_RST;
            frame_type_q   = FRAME_TYPE_RST;
            length_q       = PAYLOAD_LEN_RST;
            state          = HUNT_FIRST;
            fill_idx       = '0;
            crc_acc        = CRC_SEED;
            crc_lo         = '0;
            discards       = '0;
            goods          = '0;
            crc_errs       = '0;
            results_q.delete();
            mismatch_count = 0;
            bytes_taken    = 0;
            results_taken  = 0;
            frames_passed  = 0;
            frames_corrupt = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  sync_first_q  = cfg_data;
                    CFG_SYNC_SECOND: sync_second_q = cfg_data;
                    CFG_FRAME_TYPE:  frame_type_q  = cfg_data;
                    CFG_PAYLOAD_LEN: length_q      = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                parse_byte(byte_ch.rx_byte);
                bytes_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                results_taken++;
                if (results_q.size() == 0)
                begin
                    $error("result request arrived with no result expected");
                    mismatch_count++;
                end
                else
                begin
                    want = results_q.pop_front();
                    check_field("status", CNT_W'(want.status), CNT_W'(result_ch.status));
                    check_field("payload_byte", CNT_W'(want.payload_byte),
                                CNT_W'(result_ch.payload_byte));
                    check_field("payload_index", CNT_W'(want.payload_index),
                                CNT_W'(result_ch.payload_index));
                    check_field("last", CNT_W'(want.last), CNT_W'(result_ch.last));
                    check_field("discarded_count", want.discarded, result_ch.discarded_count);
                    check_field("good_count", want.good, result_ch.good_count);
                    check_field("crc_error_count", want.crc_errors, result_ch.crc_error_count);
                end
            end
        end
        results_due    = results_q.size();
        parser_hunting = (state == HUNT_FIRST);
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the frame parser testbench: clock, reset, register writes and byte stimulus
// under several idle and stall mixes. Depends on cfp_pkg, both channel interfaces,
// crc16_frame_parser and cfp_frame_checker with its package.

module tb;
    import cfp_pkg::*;
    import cfp_tb_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    cfp_byte_if   byte_ch ();
    cfp_result_if result_ch ();

    int   mismatch_count;
    int   results_due;
    logic parser_hunting;
    int   bytes_taken;
    int   results_taken;
    int   frames_passed;
    int   frames_corrupt;

    logic [DATA_W-1:0] cur_sf;
    logic [DATA_W-1:0] cur_ss;
    logic [DATA_W-1:0] cur_ft;
    logic [LEN_W-1:0]  cur_span;
    int                bytes_sent;
    int                idle_pct;
    int                stall_pct;

    crc16_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    cfp_frame_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .byte_ch        (byte_ch),
        .result_ch      (result_ch),
        .mismatch_count (mismatch_count),
        .results_due    (results_due),
        .parser_hunting (parser_hunting),
        .bytes_taken    (bytes_taken),
        .results_taken  (results_taken),
        .frames_passed  (frames_passed),
        .frames_corrupt (frames_corrupt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_byte(input logic [DATA_W-1:0] b);
        if ($urandom_range(99) < idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit corrupt);
        logic [CRC_W-1:0]  c;
        logic [DATA_W-1:0] p;
        send_byte(cur_sf);
        send_byte(cur_ss);
        send_byte(cur_ft);
        c = crc16_update(CRC_SEED, cur_ft);
        send_byte(DATA_W'(cur_span));
        c = crc16_update(c, DATA_W'(cur_span));
        for (int i = 0; i < int'(cur_span); i++)
        begin
            p = DATA_W'($urandom_range(255));
            send_byte(p);
            c = crc16_update(c, p);
        end
        if (corrupt)
            c = c ^ (CRC_W'(1) << $urandom_range(CRC_W - 1));
        send_byte(c[7:0]);
        send_byte(c[15:8]);
    endtask

    task automatic send_random_unit();
        int kind;
        kind = $urandom_range(99);
        if (kind < 55)
            send_frame(1'b0);
        else if (kind < 68)
            send_frame(1'b1);
        else if (kind < 76)
        begin
            send_byte(cur_sf);
            send_byte(cur_ss);
            send_byte(cur_ft ^ DATA_W'($urandom_range(1, 255)));
        end
        else if (kind < 84)
        begin
            send_byte(cur_sf);
            send_byte(cur_ss);
            send_byte(cur_ft);
            send_byte(DATA_W'(cur_span) ^ DATA_W'($urandom_range(1, 255)));
        end
        else if (kind < 90)
        begin
            send_byte(cur_sf);
            send_frame(1'b0);
        end
        else
        begin
            if ($urandom_range(1))
                send_byte(cur_sf);
            repeat ($urandom_range(1, 4))
                send_byte(DATA_W'($urandom_range(255)));
        end
    endtask

    // Holds the byte channel off until every result has drained, feeding filler bytes
    // until the parser model hunts again, so that a new register setting never lands mid-frame.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        forever
        begin
            do @(negedge clk); while (results_due != 0);
            if (parser_hunting)
                break;
            @(posedge clk);
            send_byte(~cur_sf);
            byte_ch.valid <= 1'b0;
        end
        @(posedge clk);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] sf, input logic [DATA_W-1:0] ss,
                              input logic [DATA_W-1:0] ft, input logic [LEN_W-1:0] len_reg);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data  <= sf;
        @(posedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data  <= ss;
        @(posedge clk);
        cfg_index <= CFG_FRAME_TYPE;
        cfg_data  <= ft;
        @(posedge clk);
        cfg_index <= CFG_PAYLOAD_LEN;
        cfg_data  <= DATA_W'(len_reg);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_sf    = sf;
        cur_ss    = ss;
        cur_ft    = ft;
        cur_span  = payload_span(len_reg);
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] sf, input logic [DATA_W-1:0] ss,
                             input logic [DATA_W-1:0] ft, input logic [LEN_W-1:0] len_reg,
                             input int idle, input int stall, input int budget);
        int start;
        settle();
        set_config(sf, ss, ft, len_reg);
        idle_pct  = idle;
        stall_pct = stall;
        start     = bytes_sent;
        while (bytes_sent - start < budget)
            send_random_unit();
    endtask

    initial
    begin
        logic [DATA_W-1:0] rnd_sync;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_SYNC_FIRST;
        cfg_data        = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        result_ch.ready = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        bytes_sent      = 0;
        cur_sf          = SYNC_FIRST_RST;
        cur_ss          = SYNC_SECOND_RST;
        cur_ft          = FRAME_TYPE_RST;
        cur_span        = PAYLOAD_LEN_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(8'hAA, 8'h55, 8'h01, LEN_W'(1));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'hFE);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h01);
        send_byte(8'h00);
        send_frame(1'b0);
        send_frame(1'b1);

        run_phase(8'hAA, 8'h55, 8'h01, LEN_W'(20), 0, 0, 60);
        run_phase(8'h00, 8'hFF, 8'h00, LEN_W'(0), 62, 0, 70);
        run_phase(8'hFF, 8'h00, 8'hFF, LEN_W'(32), 0, 62, 50);
        run_phase(8'h7E, 8'h7E, 8'h80, LEN_W'(63), 13, 13, 40);
        run_phase(DATA_W'($urandom_range(255)), DATA_W'($urandom_range(255)),
                  DATA_W'($urandom_range(255)), LEN_W'($urandom_range(1, 8)), 0, 62, 80);
        rnd_sync = DATA_W'($urandom_range(255));
        run_phase(rnd_sync, rnd_sync, DATA_W'($urandom_range(255)),
                  LEN_W'($urandom_range(2, 4)), 62, 0, 60);

        settle();
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes over seven register settings and four idle mixes.", bytes_sent);
        $display("Checked %0d results from %0d good frames and %0d CRC failures.",
                 results_taken, frames_passed, frames_corrupt);
        if (mismatch_count == 0 && results_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
